// ===== design/dtsk_pkg.sv =====
// Shared types and fixed field widths for the two-stack deque.
// Used by the channel interfaces, dtsk_core and the top level; depends on nothing.
package dtsk_pkg;

   localparam int ACTION_BITS = 2;
   localparam int INDEX_BITS  = 9;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 10;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_BACK  = 2'd1,
      ACT_READ       = 2'd2
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Result fields that are settled when an item is taken in, ahead of the stack read data.
   typedef struct packed {
      logic                  read_ok;
      logic                  from_front;
      status_type            status;
      logic [COUNT_BITS-1:0] total_count;
      logic                  is_empty;
   } stage_ctl_type;

endpackage

// ===== design/dtsk_chan_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the deque.
// Depends on dtsk_pkg for the fixed field widths.
interface dtsk_req_if import dtsk_pkg::*; #(
   parameter int WORD_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [WORD_BITS-1:0]   push_word;
   logic [INDEX_BITS-1:0]  read_index;

   modport source (output valid, action, push_word, read_index, input ready);
   modport sink   (input valid, action, push_word, read_index, output ready);
endinterface

interface dtsk_rsp_if import dtsk_pkg::*; #(
   parameter int WORD_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic [WORD_BITS-1:0]   read_word;
   logic [STATUS_BITS-1:0] status;
   logic [COUNT_BITS-1:0]  total_count;
   logic                   is_empty;
   logic [WORD_BITS-1:0]   front_word;
   logic [WORD_BITS-1:0]   back_word;

   modport source (output valid, read_word, status, total_count, is_empty, front_word,
                   back_word, input ready);
   modport sink   (input valid, read_word, status, total_count, is_empty, front_word,
                   back_word, output ready);
endinterface

// ===== design/dtsk_stack_mem.sv =====
// Storage for one stack: a single write port and a single read port with registered data.
// Depends on nothing; instantiated twice by the top level.
module dtsk_stack_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // The read register holds its value between reads so a stalled item keeps its data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dtsk_core.sv =====
// Fill counters, end-word registers and request decode for the two-stack deque.
// Depends on dtsk_pkg; drives the ports of both stack memories and the first pipeline stage.
module dtsk_core import dtsk_pkg::*; #(
   parameter int SIDE_DEPTH = 256,
   parameter int WORD_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ACTION_BITS-1:0]        action,
   input  logic [WORD_BITS-1:0]          push_word,
   input  logic [INDEX_BITS-1:0]         read_index,
   output logic                          fwr_en,
   output logic [$clog2(SIDE_DEPTH)-1:0] fwr_addr,
   output logic                          bwr_en,
   output logic [$clog2(SIDE_DEPTH)-1:0] bwr_addr,
   output logic                          frd_en,
   output logic [$clog2(SIDE_DEPTH)-1:0] frd_addr,
   output logic                          brd_en,
   output logic [$clog2(SIDE_DEPTH)-1:0] brd_addr,
   output stage_ctl_type                 stage_ctl,
   output logic [WORD_BITS-1:0]          stage_front,
   output logic [WORD_BITS-1:0]          stage_back
);

   localparam int FILL_BITS = $clog2(SIDE_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(SIDE_DEPTH);
   localparam int SUM_BITS  = FILL_BITS + 1;
   localparam int CMP_BITS  = (SUM_BITS > INDEX_BITS) ? SUM_BITS : INDEX_BITS;

   logic [FILL_BITS-1:0] front_fill_ff, front_fill_in;
   logic [FILL_BITS-1:0] back_fill_ff, back_fill_in;
   logic [WORD_BITS-1:0] front_top_ff, front_top_in;
   logic [WORD_BITS-1:0] front_bot_ff, front_bot_in;
   logic [WORD_BITS-1:0] back_top_ff, back_top_in;
   logic [WORD_BITS-1:0] back_bot_ff, back_bot_in;
   stage_ctl_type        ctl_ff, ctl_in;
   logic [WORD_BITS-1:0] front_word_ff, front_word_in;
   logic [WORD_BITS-1:0] back_word_ff, back_word_in;

   logic                 front_full, back_full;
   logic [CMP_BITS-1:0]  idx_w, front_w, total_now;
   logic [CMP_BITS-1:0]  front_off, back_off;
   logic                 in_front, in_range;
   logic [SUM_BITS-1:0]  total_in;
   status_type           status;
   logic                 read_ok;

   assign front_full = (front_fill_ff == FILL_BITS'(SIDE_DEPTH));
   assign back_full  = (back_fill_ff == FILL_BITS'(SIDE_DEPTH));

   // Positions below the front fill count run down the front stack from its top;
   // the rest run up the back stack from its bottom.
   assign idx_w     = CMP_BITS'(read_index);
   assign front_w   = CMP_BITS'(front_fill_ff);
   assign total_now = CMP_BITS'(SUM_BITS'(front_fill_ff) + SUM_BITS'(back_fill_ff));
   assign in_front  = (idx_w < front_w);
   assign in_range  = (idx_w < total_now);
   assign front_off = front_w - idx_w - CMP_BITS'(1);
   assign back_off  = idx_w - front_w;

   assign fwr_addr = front_fill_ff[ADDR_BITS-1:0];
   assign bwr_addr = back_fill_ff[ADDR_BITS-1:0];
   assign frd_addr = front_off[ADDR_BITS-1:0];
   assign brd_addr = back_off[ADDR_BITS-1:0];

   always_comb begin
      front_fill_in = front_fill_ff;
      back_fill_in  = back_fill_ff;
      front_top_in  = front_top_ff;
      front_bot_in  = front_bot_ff;
      back_top_in   = back_top_ff;
      back_bot_in   = back_bot_ff;
      fwr_en        = 1'b0;
      bwr_en        = 1'b0;
      frd_en        = 1'b0;
      brd_en        = 1'b0;
      status        = ST_OK;
      read_ok       = 1'b0;
      if (accept) begin
         case (action_type'(action))
            ACT_PUSH_FRONT: begin
               if (front_full) begin
                  status = ST_FULL;
               end else begin
                  fwr_en        = 1'b1;
                  front_fill_in = front_fill_ff + FILL_BITS'(1);
                  front_top_in  = push_word;
                  if (front_fill_ff == '0) begin
                     front_bot_in = push_word;
                  end
               end
            end
            ACT_PUSH_BACK: begin
               if (back_full) begin
                  status = ST_FULL;
               end else begin
                  bwr_en       = 1'b1;
                  back_fill_in = back_fill_ff + FILL_BITS'(1);
                  back_top_in  = push_word;
                  if (back_fill_ff == '0) begin
                     back_bot_in = push_word;
                  end
               end
            end
            ACT_READ: begin
               if (!in_range) begin
                  status = ST_RANGE;
               end else begin
                  read_ok = 1'b1;
                  frd_en  = in_front;
                  brd_en  = !in_front;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The end words are taken from the state as it stands after this item.
   always_comb begin
      total_in      = SUM_BITS'(front_fill_in) + SUM_BITS'(back_fill_in);
      front_word_in = '0;
      back_word_in  = '0;
      if (total_in != '0) begin
         front_word_in = (front_fill_in != '0) ? front_top_in : back_bot_in;
         back_word_in  = (back_fill_in != '0) ? back_top_in : front_bot_in;
      end
      ctl_in.read_ok     = read_ok;
      ctl_in.from_front  = in_front;
      ctl_in.status      = status;
      ctl_in.total_count = COUNT_BITS'(total_in);
      ctl_in.is_empty    = (total_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_fill_ff <= '0;
         back_fill_ff  <= '0;
      end else begin
         front_fill_ff <= front_fill_in;
         back_fill_ff  <= back_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      front_top_ff <= front_top_in;
      front_bot_ff <= front_bot_in;
      back_top_ff  <= back_top_in;
      back_bot_ff  <= back_bot_in;
      if (accept) begin
         ctl_ff        <= ctl_in;
         front_word_ff <= front_word_in;
         back_word_ff  <= back_word_in;
      end
   end

   assign stage_ctl   = ctl_ff;
   assign stage_front = front_word_ff;
   assign stage_back  = back_word_ff;

   a_front_fill_bound: assert property (@(posedge clock) disable iff (reset)
      front_fill_ff <= FILL_BITS'(SIDE_DEPTH))
      else $error("front fill count beyond stack depth");

   a_back_fill_bound: assert property (@(posedge clock) disable iff (reset)
      back_fill_ff <= FILL_BITS'(SIDE_DEPTH))
      else $error("back fill count beyond stack depth");

   a_one_stack_read: assert property (@(posedge clock) disable iff (reset)
      !(frd_en && brd_en) && !((frd_en || brd_en) && (fwr_en || bwr_en)))
      else $error("more than one stack access for a single item");

   a_front_push_grows: assert property (@(posedge clock) disable iff (reset)
      fwr_en |=> front_fill_ff == $past(front_fill_ff) + FILL_BITS'(1))
      else $error("front push did not advance the fill count");

endmodule

// ===== design/deque_from_two_stacks.sv =====
// Double-ended word store built from two stacks, one request per transfer.
// Request channel (req_ch): action 0 pushes push_word at the front, 1 pushes it at the
// back, 2 reads the word at read_index counted from the front; code 3 does nothing.
// Response channel (rsp_ch): exactly one response per request, in request order, with
// the read word (zero unless the read succeeded), a status (ok, index out of range,
// push side full), the word count, an empty flag and the front and back words (zero
// when empty). A push to a full side is dropped and reported as full.
// Throughput: one request per cycle while the receiver takes each response; the pipeline
// is the fill-count update with the stack write or read in the first stage, and the
// stack read-data select into the response register in the second. Each stack memory
// sees at most one write or one read per item.
// Reset (synchronous, active high) empties both stacks by clearing the fill counts;
// stack contents are not cleared and no clearing pass is needed. While the receiver
// stalls, the response holds and up to one further request is taken into the first
// stage; then req_ch.ready drops until the response is taken.
// Depends on dtsk_pkg, dtsk_chan_if, dtsk_stack_mem and dtsk_core.
module deque_from_two_stacks import dtsk_pkg::*; #(
   parameter int SIDE_DEPTH = 256,
   parameter int WORD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   dtsk_req_if.sink    req_ch,
   dtsk_rsp_if.source  rsp_ch
);

   localparam int ADDR_BITS = $clog2(SIDE_DEPTH);

   logic                 accept;
   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_move;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_read_ff;
   status_type           rsp_status_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                 rsp_empty_ff;
   logic [WORD_BITS-1:0] rsp_front_ff, rsp_back_ff;

   logic                 fwr_en, bwr_en, frd_en, brd_en;
   logic [ADDR_BITS-1:0] fwr_addr, bwr_addr, frd_addr, brd_addr;
   logic [WORD_BITS-1:0] frd_data, brd_data;
   stage_ctl_type        stage_ctl;
   logic [WORD_BITS-1:0] stage_front, stage_back;
   logic [WORD_BITS-1:0] read_sel;

   assign stage_move     = stage_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !stage_valid_ff || stage_move;
   assign accept         = req_ch.valid && req_ch.ready;
   assign stage_valid_in = accept || (stage_valid_ff && !stage_move);
   assign rsp_valid_in   = stage_move || (rsp_valid_ff && !rsp_ch.ready);

   dtsk_core #(
      .SIDE_DEPTH (SIDE_DEPTH),
      .WORD_BITS  (WORD_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_ch.action),
      .push_word   (req_ch.push_word),
      .read_index  (req_ch.read_index),
      .fwr_en      (fwr_en),
      .fwr_addr    (fwr_addr),
      .bwr_en      (bwr_en),
      .bwr_addr    (bwr_addr),
      .frd_en      (frd_en),
      .frd_addr    (frd_addr),
      .brd_en      (brd_en),
      .brd_addr    (brd_addr),
      .stage_ctl   (stage_ctl),
      .stage_front (stage_front),
      .stage_back  (stage_back)
   );

   dtsk_stack_mem #(
      .DEPTH (SIDE_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_front_mem (
      .clock   (clock),
      .wr_en   (fwr_en),
      .wr_addr (fwr_addr),
      .wr_data (req_ch.push_word),
      .rd_en   (frd_en),
      .rd_addr (frd_addr),
      .rd_data (frd_data)
   );

   dtsk_stack_mem #(
      .DEPTH (SIDE_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_back_mem (
      .clock   (clock),
      .wr_en   (bwr_en),
      .wr_addr (bwr_addr),
      .wr_data (req_ch.push_word),
      .rd_en   (brd_en),
      .rd_addr (brd_addr),
      .rd_data (brd_data)
   );

   always_comb begin
      read_sel = '0;
      if (stage_ctl.read_ok) begin
         read_sel = stage_ctl.from_front ? frd_data : brd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_read_ff   <= read_sel;
         rsp_status_ff <= stage_ctl.status;
         rsp_count_ff  <= stage_ctl.total_count;
         rsp_empty_ff  <= stage_ctl.is_empty;
         rsp_front_ff  <= stage_front;
         rsp_back_ff   <= stage_back;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_word   = rsp_read_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.total_count = rsp_count_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
   assign rsp_ch.front_word  = rsp_front_ff;
   assign rsp_ch.back_word   = rsp_back_ff;

   a_stage_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_move) |-> !req_ch.ready)
      else $error("request taken while the first stage is held");

   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      stage_move |=> rsp_valid_ff)
      else $error("first-stage item lost on its way to the response register");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_valid_ff)
      else $error("accepted request did not enter the first stage");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the two-stack deque, top level deque_from_two_stacks.
// Drives requests with random idling, predicts every response in step and checks it.
// Depends on dtsk_pkg, the dtsk_req_if and dtsk_rsp_if channel interfaces and the RTL.
module testbench;
   import dtsk_pkg::*;

   localparam int SIDE_DEPTH  = 256;
   localparam int WORD_BITS   = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;

   // Action code 3 is not in the package; the block treats it as a no-operation.
   localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [WORD_BITS-1:0]  read_word;
      status_type            status;
      logic [COUNT_BITS-1:0] total_count;
      logic                  is_empty;
      logic [WORD_BITS-1:0]  front_word;
      logic [WORD_BITS-1:0]  back_word;
   } deque_view_type;

   logic clock;
   logic reset;

   dtsk_req_if #(.WORD_BITS(WORD_BITS)) req_ch ();
   dtsk_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_ch ();

   deque_from_two_stacks #(
      .SIDE_DEPTH (SIDE_DEPTH),
      .WORD_BITS  (WORD_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Shadow copy of the deque, updated as each request transfer is accepted.
   logic [WORD_BITS-1:0] front_mem [SIDE_DEPTH];
   logic [WORD_BITS-1:0] back_mem  [SIDE_DEPTH];
   int                   front_count = 0;
   int                   back_count  = 0;

   deque_view_type pending_views [$];
   int          mismatches  = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [WORD_BITS-1:0] word_at_position(int pos);
      if (pos < front_count) begin
         return front_mem[front_count - 1 - pos];
      end
      return back_mem[pos - front_count];
   endfunction

   // Applies one action to the shadow deque and returns the response it should produce.
   function automatic deque_view_type apply_action(logic [ACTION_BITS-1:0] act,
                                                   logic [WORD_BITS-1:0] word,
                                                   logic [INDEX_BITS-1:0] idx);
      deque_view_type view;
      int          total;
      view = '0;
      view.status = ST_OK;
      case (act)
         ACT_PUSH_FRONT: begin
            if (front_count >= SIDE_DEPTH) begin
               view.status = ST_FULL;
            end else begin
               front_mem[front_count] = word;
               front_count++;
            end
         end
         ACT_PUSH_BACK: begin
            if (back_count >= SIDE_DEPTH) begin
               view.status = ST_FULL;
            end else begin
               back_mem[back_count] = word;
               back_count++;
            end
         end
         ACT_READ: begin
            if (int'(idx) >= front_count + back_count) begin
               view.status = ST_RANGE;
            end else begin
               view.read_word = word_at_position(int'(idx));
            end
         end
         default: ;
      endcase
      total = front_count + back_count;
      view.total_count = COUNT_BITS'(total);
      view.is_empty    = (total == 0);
      if (total != 0) begin
         view.front_word = (front_count != 0) ? front_mem[front_count - 1] : back_mem[0];
         view.back_word  = (back_count != 0) ? back_mem[back_count - 1] : front_mem[0];
      end
      return view;
   endfunction

   // Presents one request, idling beforehand at the current rate, and returns once
   // the transfer has been accepted.
   task automatic send_request(input logic [ACTION_BITS-1:0] act,
                               input logic [WORD_BITS-1:0] word,
                               input logic [INDEX_BITS-1:0] idx);
      deque_view_type expected;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.push_word  <= word;
      req_ch.read_index <= idx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected = apply_action(act, word, idx);
      pending_views.insert(pending_views.size(), expected);
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_views.size() == 0) begin
            $error("response transfer with no request outstanding");
            mismatches++;
         end else begin
            want = pending_views.pop_front();
            if (rsp_ch.read_word !== want.read_word) begin
               $error("read_word: expected %h, got %h", want.read_word, rsp_ch.read_word);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.total_count !== want.total_count) begin
               $error("total_count: expected %0d, got %0d", want.total_count,
                      rsp_ch.total_count);
               mismatches++;
            end
            if (rsp_ch.is_empty !== want.is_empty) begin
               $error("is_empty: expected %b, got %b", want.is_empty, rsp_ch.is_empty);
               mismatches++;
            end
            if (rsp_ch.front_word !== want.front_word) begin
               $error("front_word: expected %h, got %h", want.front_word, rsp_ch.front_word);
               mismatches++;
            end
            if (rsp_ch.back_word !== want.back_word) begin
               $error("back_word: expected %h, got %h", want.back_word, rsp_ch.back_word);
               mismatches++;
            end
         end
      end
   end

   // Reads, no-operations and out-of-range reads on a deque that holds nothing.
   task automatic test_empty_deque();
      send_request(ACT_READ, 32'h0000_0000, 9'd0);
      send_request(ACT_READ, 32'hFFFF_FFFF, 9'd511);
      send_request(ACT_NONE, 32'hFFFF_FFFF, 9'd511);
      send_request(ACT_NONE, 32'h0000_0000, 9'd0);
      send_request(ACT_READ, 32'h1234_5678, 9'h155);
   endtask

   // Only the front stack holds words, so the back word is the bottom of the front stack.
   task automatic test_front_only();
      send_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 9'd0);
      send_request(ACT_PUSH_FRONT, 32'h0000_0000, 9'd511);
      send_request(ACT_PUSH_FRONT, 32'hA5A5_A5A5, 9'h0AA);
      for (int i = 0; i < 4; i++) begin
         send_request(ACT_READ, $urandom, INDEX_BITS'(i));
      end
      send_request(ACT_NONE, $urandom, 9'd1);
   endtask

   // Words on both sides: reads that cross from the front stack into the back stack.
   task automatic test_both_sides();
      send_request(ACT_PUSH_BACK, 32'h1234_5678, 9'd0);
      send_request(ACT_PUSH_BACK, 32'hFFFF_0000, 9'd511);
      for (int i = 0; i < 6; i++) begin
         send_request(ACT_READ, $urandom, INDEX_BITS'(i));
      end
      send_request(ACT_READ, 32'h0, 9'd511);
      send_request(ACT_NONE, 32'h5A5A_5A5A, 9'd3);
   endtask

   // Mostly reads with a steady trickle of pushes, so the deque grows through the run.
   task automatic test_random_traffic(input int item_total);
      int pick;
      int size;
      logic [INDEX_BITS-1:0] idx;
      for (int n = 0; n < item_total; n++) begin
         pick = $urandom_range(0, 99);
         size = front_count + back_count;
         if (size != 0 && $urandom_range(0, 99) < 70) begin
            idx = INDEX_BITS'($urandom_range(0, size - 1));
         end else begin
            idx = INDEX_BITS'($urandom_range(0, 511));
         end
         if (pick < 12) begin
            send_request(ACT_PUSH_FRONT, $urandom, idx);
         end else if (pick < 24) begin
            send_request(ACT_PUSH_BACK, $urandom, idx);
         end else if (pick < 28) begin
            send_request(ACT_NONE, $urandom, idx);
         end else begin
            send_request(ACT_READ, $urandom, idx);
         end
      end
   endtask

   // Fills both stacks to the top, then pushes to full sides and reads across the whole range.
   task automatic test_full_sides();
      while (front_count < SIDE_DEPTH) begin
         send_request(ACT_PUSH_FRONT, $urandom, INDEX_BITS'($urandom_range(0, 511)));
      end
      send_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 9'd0);
      send_request(ACT_READ, 32'h0, INDEX_BITS'(SIDE_DEPTH - 1));
      while (back_count < SIDE_DEPTH) begin
         send_request(ACT_PUSH_BACK, $urandom, INDEX_BITS'($urandom_range(0, 511)));
      end
      send_request(ACT_PUSH_BACK, 32'hFFFF_FFFF, 9'd511);
      send_request(ACT_PUSH_FRONT, 32'h0, 9'd0);
      send_request(ACT_READ, 32'h0, 9'd0);
      send_request(ACT_READ, 32'h0, INDEX_BITS'(SIDE_DEPTH));
      send_request(ACT_READ, 32'h0, 9'd511);
      send_request(ACT_NONE, 32'hFFFF_FFFF, 9'd511);
      for (int n = 0; n < 60; n++) begin
         send_request(ACT_READ, $urandom, INDEX_BITS'($urandom_range(0, 511)));
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_NONE;
      req_ch.push_word  <= '0;
      req_ch.read_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 67;
      test_empty_deque();
      test_front_only();
      test_both_sides();
      test_random_traffic(500);
      // The sender holds off here until the block has returned every response.
      wait_for_responses();

      send_idle_pct = 67;
      recv_idle_pct = 13;
      test_random_traffic(500);
      wait_for_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(500);
      test_full_sides();
      wait_for_responses();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
